// ===== sv/gvp_pkg.sv =====
// gvp_pkg: types, constants and helper functions of the geostationary view projection
// used by the channel interfaces, the cordic cells and the top level
// no dependencies
package gvp_pkg;

    // internal angle width, degrees with 24 fractional bits
    localparam int ZW    = 33;
    // datapath widths of the cordic chains, the radius and height and the cartesian x, y
    localparam int W_ROT = 32;
    localparam int W_VB  = 58;
    localparam int W_VD  = 39;
    localparam int W_LEN = 36;
    localparam int W_XY  = 37;

    localparam int EXACT_STEPS = 12;

    localparam logic signed [W_ROT-1:0] INV_GAIN    = 32'sd163008219;
    localparam longint                  DEG_PER_RAD = 64'd961263669;

    localparam logic signed [26:0] D90_Q16  = 27'sd5898240;
    localparam logic signed [26:0] D180_Q16 = 27'sd11796480;
    localparam logic signed [26:0] D360_Q16 = 27'sd23592960;

    localparam logic signed [ZW-1:0] ATAN_TAB [EXACT_STEPS] = '{
        33'sd754974720, 33'sd445687602, 33'sd235489088, 33'sd119537938,
        33'sd60000934,  33'sd30029717,  33'sd15018523,  33'sd7509720,
        33'sd3754917,   33'sd1877466,   33'sd938734,    33'sd469367
    };

    // register indexes of the configuration port
    localparam logic [2:0] CFG_VIEW_LON    = 3'd0;
    localparam logic [2:0] CFG_TRANSPARENT = 3'd1;
    localparam logic [2:0] CFG_POLAR       = 3'd2;
    localparam logic [2:0] CFG_EQUATORIAL  = 3'd3;
    localparam logic [2:0] CFG_ORBIT       = 3'd4;

    localparam logic [25:0] RST_POLAR      = 26'd6356752;
    localparam logic [25:0] RST_EQUATORIAL = 26'd6378137;
    localparam logic [25:0] RST_ORBIT      = 26'd42164000;

    typedef struct packed {
        logic hidden;
        logic pole;
        logic neg;
        logic th_flip;
    } t_flags;

    typedef struct packed {
        logic signed [ZW-1:0] ang;
        logic                 flip;
    } t_fold;

    typedef struct packed {
        logic signed [23:0] x_angle;
        logic signed [23:0] y_angle;
        logic               hidden;
    } t_res;

    // atan(2^-i) in degrees q24
    function automatic logic signed [ZW-1:0] step_angle(input int i);
        longint t;
        t = 0;
        if (i < EXACT_STEPS) begin
            return ATAN_TAB[i];
        end
        t = (DEG_PER_RAD + (longint'(1) << (i - 1))) >> i;
        return ZW'(t);
    endfunction

    // reduce modulo 360 and fold to +-90, result in q24
    function automatic t_fold fold_angle(input logic signed [26:0] a);
        logic signed [26:0] r;
        t_fold f;
        r = a;
        f.flip = 1'b0;
        if (r >= D360_Q16) begin
            r = r - D360_Q16;
        end else if (r <= -D360_Q16) begin
            r = r + D360_Q16;
        end
        if (r < -D180_Q16) begin
            r = r + D360_Q16;
        end else if (r >= D180_Q16) begin
            r = r - D360_Q16;
        end
        if (r > D90_Q16) begin
            r = r - D180_Q16;
            f.flip = 1'b1;
        end else if (r < -D90_Q16) begin
            r = r + D180_Q16;
            f.flip = 1'b1;
        end
        f.ang = ZW'(r) <<< 8;
        return f;
    endfunction

    // round q24 to q16 and saturate to +-90 degrees
    function automatic logic signed [23:0] angle_out(input logic signed [ZW-1:0] a);
        logic signed [ZW:0] t;
        logic signed [ZW:0] r;
        t = (ZW+1)'(a) + 34'sd128;
        r = t >>> 8;
        if (r > (ZW+1)'(D90_Q16)) begin
            r = (ZW+1)'(D90_Q16);
        end else if (r < -(ZW+1)'(D90_Q16)) begin
            r = -(ZW+1)'(D90_Q16);
        end
        return r[23:0];
    endfunction

endpackage

// ===== sv/gvp_if.sv =====
// gvp_if: request channels of the geostationary view projection
// point input, angle result and configuration write
// depends on gvp_pkg
interface gvp_in_if;
    import gvp_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [24:0] longitude;
    logic signed [23:0] latitude;
    modport source (output valid, output longitude, output latitude, input ready);
    modport sink (input valid, input longitude, input latitude, output ready);
endinterface

interface gvp_out_if;
    import gvp_pkg::*;
    logic               valid;
    logic               ready;
    logic signed [23:0] x_angle;
    logic signed [23:0] y_angle;
    logic               hidden;
    modport source (output valid, output x_angle, output y_angle, output hidden,
                    input ready);
    modport sink (input valid, input x_angle, input y_angle, input hidden,
                  output ready);
endinterface

interface gvp_cfg_if;
    import gvp_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [25:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/gvp_rot_cell.sv =====
// gvp_rot_cell: one rotation-mode cordic iteration with its output register
// depends on gvp_pkg
module gvp_rot_cell #(
    parameter int W    = 32,
    parameter int STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [W-1:0]           i_x,
    input  logic signed [W-1:0]           i_y,
    input  logic signed [gvp_pkg::ZW-1:0] i_z,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic signed [gvp_pkg::ZW-1:0] o_z
);
    import gvp_pkg::*;

    localparam logic signed [ZW-1:0] ANG = step_angle(STEP);

    logic signed [W-1:0]  dx, dy, n_x, n_y, r_x, r_y;
    logic signed [ZW-1:0] n_z, r_z;

    assign dx = i_y >>> STEP;
    assign dy = i_x >>> STEP;

    always_comb begin
        if (i_z >= 0) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ANG;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// ===== sv/gvp_vec_cell.sv =====
// gvp_vec_cell: one vectoring-mode cordic iteration with its output register
// depends on gvp_pkg
module gvp_vec_cell #(
    parameter int W    = 39,
    parameter int STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [W-1:0]           i_x,
    input  logic signed [W-1:0]           i_y,
    input  logic signed [gvp_pkg::ZW-1:0] i_z,
    output logic signed [W-1:0]           o_x,
    output logic signed [W-1:0]           o_y,
    output logic signed [gvp_pkg::ZW-1:0] o_z
);
    import gvp_pkg::*;

    localparam logic signed [ZW-1:0] ANG = step_angle(STEP);

    logic signed [W-1:0]  dx, dy, n_x, n_y, r_x, r_y;
    logic signed [ZW-1:0] n_z, r_z;

    assign dx = i_y >>> STEP;
    assign dy = i_x >>> STEP;

    // drive y towards zero, accumulate the angle
    always_comb begin
        if (i_y >= 0) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ANG;
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

// ===== sv/geostationary_view_projection_core.sv =====
// geostationary_view_projection_core: projects longitude and latitude onto
// the view angles of a geostationary satellite over an ellipsoidal earth
// depends on gvp_pkg, gvp_if, gvp_rot_cell, gvp_vec_cell
//
// channels: i_in takes a point request (longitude, latitude in degrees q16),
// o_out returns one result request (x_angle, y_angle, hidden) per point, in
// order. i_cfg writes the five configuration registers by index and is always
// ready; write it only while no point is in flight.
// pipeline: an accepted point passes the input register (loaded at the
// accepting edge), four cordic chains in series with one cell per iteration,
// three multiply stages, the distance stage and the output register before
// o_out.valid rises.
// throughput: one point per cycle; the chain of cells advances every cycle
// that the output skid register is empty.
// stall: a result that meets a stalled receiver parks in a skid register,
// then the whole chain holds until the receiver takes a result.
// reset: flushes all requests in flight and restores the default radii,
// zero view longitude and opaque globe.
module geostationary_view_projection_core #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gvp_in_if.sink     i_in,
    gvp_out_if.source  o_out,
    gvp_cfg_if.sink    i_cfg
);
    import gvp_pkg::*;

    localparam int N   = CORDIC_STEPS;
    localparam int L   = 4 * N + 5;
    localparam int C_I = 2 * N + 1;
    localparam int M2  = 3 * N + 2;

    // configuration
    logic signed [24:0] r_view;
    logic               r_tg;
    logic [25:0]        r_pol, r_eq, r_orb;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view <= '0;
            r_tg   <= 1'b0;
            r_pol  <= RST_POLAR;
            r_eq   <= RST_EQUATORIAL;
            r_orb  <= RST_ORBIT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_VIEW_LON:    r_view <= i_cfg.data[24:0];
                CFG_TRANSPARENT: r_tg   <= i_cfg.data[0];
                CFG_POLAR:       r_pol  <= i_cfg.data;
                CFG_EQUATORIAL:  r_eq   <= i_cfg.data;
                CFG_ORBIT:       r_orb  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // flow control
    logic         en;
    logic [L-1:0] r_vld;
    logic         r_out_v, r_skid_v;
    t_res         r_out, r_skid, res;

    assign en         = !r_skid_v;
    assign i_in.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_in.valid};
        end
    end

    // front stage
    logic signed [25:0] dq;
    logic signed [24:0] alat;
    t_fold              f_lat, f_th;
    t_flags             n_flag;

    assign dq    = 26'(i_in.longitude) - 26'(r_view);
    assign alat  = i_in.latitude[23] ? -25'(i_in.latitude) : 25'(i_in.latitude);
    assign f_lat = fold_angle(27'(alat));
    assign f_th  = fold_angle(27'(dq));

    always_comb begin
        n_flag.hidden  = !r_tg && (27'(dq) > D90_Q16 || 27'(dq) < -D90_Q16);
        n_flag.pole    = (27'(alat) == D90_Q16);
        n_flag.neg     = i_in.latitude[23];
        n_flag.th_flip = f_th.flip;
    end

    t_flags               r_flag [L];
    logic signed [ZW-1:0] r_th [C_I+1];
    logic signed [ZW-1:0] r_lat_ang;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat_ang <= f_lat.ang;
            r_flag[0] <= n_flag;
            r_th[0]   <= f_th.ang;
            for (int k = 1; k < L; k++) begin
                r_flag[k] <= r_flag[k-1];
            end
            for (int k = 1; k <= C_I; k++) begin
                r_th[k] <= r_th[k-1];
            end
        end
    end

    // latitude sine and cosine
    logic signed [W_ROT-1:0] la_x [N+1];
    logic signed [W_ROT-1:0] la_y [N+1];
    logic signed [ZW-1:0]    la_z [N+1];

    assign la_x[0] = INV_GAIN;
    assign la_y[0] = '0;
    assign la_z[0] = r_lat_ang;

    for (genvar i = 0; i < N; i++) begin : g_lat
        gvp_rot_cell #(.W(W_ROT), .STEP(i)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_x(la_x[i]), .i_y(la_y[i]), .i_z(la_z[i]),
            .o_x(la_x[i+1]), .o_y(la_y[i+1]), .o_z(la_z[i+1])
        );
    end

    // b*|cos|, a*|sin|
    logic [W_ROT-1:0]       uc, us;
    logic [W_VB-1:0]        p_bc, p_as;
    logic signed [W_VB-1:0] r_bc, r_as;

    assign uc   = la_x[N] < 0 ? W_ROT'(-la_x[N]) : W_ROT'(la_x[N]);
    assign us   = la_y[N] < 0 ? W_ROT'(-la_y[N]) : W_ROT'(la_y[N]);
    assign p_bc = W_VB'(r_pol) * W_VB'(uc);
    assign p_as = W_VB'(r_eq) * W_VB'(us);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bc <= signed'(p_bc);
            r_as <= signed'(p_as);
        end
    end

    // parametric latitude psi
    logic signed [W_VB-1:0] vb_x [N+1];
    logic signed [W_VB-1:0] vb_y [N+1];
    logic signed [ZW-1:0]   vb_z [N+1];

    assign vb_x[0] = r_bc;
    assign vb_y[0] = r_as;
    assign vb_z[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_psi
        gvp_vec_cell #(.W(W_VB), .STEP(i)) u_cell (
            .i_clk(i_clk), .i_en(en),
            .i_x(vb_x[i]), .i_y(vb_y[i]), .i_z(vb_z[i]),
            .o_x(vb_x[i+1]), .o_y(vb_y[i+1]), .o_z(vb_z[i+1])
        );
    end

    // cos and sin of psi and of the longitude difference, side by side
    logic signed [W_ROT-1:0] pc_x [N+1];
    logic signed [W_ROT-1:0] pc_y [N+1];
    logic signed [ZW-1:0]    pc_z [N+1];
    logic signed [W_ROT-1:0] tc_x [N+1];
    logic signed [W_ROT-1:0] tc_y [N+1];
    logic signed [ZW-1:0]    tc_z [N+1];

    assign pc_x[0] = INV_GAIN;
    assign pc_y[0] = '0;
    assign pc_z[0] = vb_z[N];
    assign tc_x[0] = INV_GAIN;
    assign tc_y[0] = '0;
    assign tc_z[0] = r_th[C_I];

    for (genvar i = 0; i < N; i++) begin : g_rot
        gvp_rot_cell #(.W(W_ROT), .STEP(i)) u_psi (
            .i_clk(i_clk), .i_en(en),
            .i_x(pc_x[i]), .i_y(pc_y[i]), .i_z(pc_z[i]),
            .o_x(pc_x[i+1]), .o_y(pc_y[i+1]), .o_z(pc_z[i+1])
        );
        gvp_rot_cell #(.W(W_ROT), .STEP(i)) u_th (
            .i_clk(i_clk), .i_en(en),
            .i_x(tc_x[i]), .i_y(tc_y[i]), .i_z(tc_z[i]),
            .o_x(tc_x[i+1]), .o_y(tc_y[i+1]), .o_z(tc_z[i+1])
        );
    end

    // radial radius and height
    t_flags                  fl2;
    logic signed [58:0]      p_rad, p_zz;
    logic signed [58:0]      s_rad, s_zz;
    logic signed [W_LEN-1:0] n_rad, n_zz, r_rad, r_zz2;
    logic signed [W_ROT-1:0] r_ct, r_st;

    assign fl2   = r_flag[M2-1];
    assign p_rad = $signed({1'b0, r_eq}) * pc_x[N];
    assign p_zz  = $signed({1'b0, r_pol}) * pc_y[N];
    assign s_rad = p_rad >>> 20;
    assign s_zz  = p_zz >>> 20;

    always_comb begin
        if (fl2.pole) begin
            n_rad = '0;
            n_zz  = $signed({2'b00, r_pol, 8'h00});
        end else begin
            n_rad = s_rad < 0 ? '0 : W_LEN'(s_rad);
            n_zz  = s_zz < 0 ? '0 : W_LEN'(s_zz);
        end
        if (fl2.neg) begin
            n_zz = -n_zz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad <= n_rad;
            r_zz2 <= n_zz;
            r_ct  <= fl2.th_flip ? -tc_x[N] : tc_x[N];
            r_st  <= fl2.th_flip ? -tc_y[N] : tc_y[N];
        end
    end

    // cartesian x, y
    logic signed [67:0]     p_x, p_y;
    logic signed [W_XY-1:0] r_x, r_y;
    logic signed [W_LEN-1:0] r_zz3;

    assign p_x = r_rad * r_ct;
    assign p_y = r_rad * r_st;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x   <= W_XY'(p_x >>> 28);
            r_y   <= W_XY'(p_y >>> 28);
            r_zz3 <= r_zz2;
        end
    end

    // distance along the view axis, mirrored when behind the satellite
    logic signed [W_VD-1:0] dd;
    logic signed [W_VD-1:0] r_d, r_dy, r_dz;

    assign dd = $signed({5'b00000, r_orb, 8'h00}) - W_VD'(r_x);

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (dd < 0) begin
                r_d  <= -dd;
                r_dy <= -W_VD'(r_y);
                r_dz <= -W_VD'(r_zz3);
            end else begin
                r_d  <= dd;
                r_dy <= W_VD'(r_y);
                r_dz <= W_VD'(r_zz3);
            end
        end
    end

    // view angles
    logic signed [W_VD-1:0] vx_x [N+1];
    logic signed [W_VD-1:0] vx_y [N+1];
    logic signed [ZW-1:0]   vx_z [N+1];
    logic signed [W_VD-1:0] vy_x [N+1];
    logic signed [W_VD-1:0] vy_y [N+1];
    logic signed [ZW-1:0]   vy_z [N+1];

    assign vx_x[0] = r_d;
    assign vx_y[0] = r_dy;
    assign vx_z[0] = '0;
    assign vy_x[0] = r_d;
    assign vy_y[0] = r_dz;
    assign vy_z[0] = '0;

    for (genvar i = 0; i < N; i++) begin : g_view
        gvp_vec_cell #(.W(W_VD), .STEP(i)) u_ax (
            .i_clk(i_clk), .i_en(en),
            .i_x(vx_x[i]), .i_y(vx_y[i]), .i_z(vx_z[i]),
            .o_x(vx_x[i+1]), .o_y(vx_y[i+1]), .o_z(vx_z[i+1])
        );
        gvp_vec_cell #(.W(W_VD), .STEP(i)) u_ay (
            .i_clk(i_clk), .i_en(en),
            .i_x(vy_x[i]), .i_y(vy_y[i]), .i_z(vy_z[i]),
            .o_x(vy_x[i+1]), .o_y(vy_y[i+1]), .o_z(vy_z[i+1])
        );
    end

    always_comb begin
        res.hidden  = r_flag[L-1].hidden;
        res.x_angle = res.hidden ? '0 : angle_out(vx_z[N]);
        res.y_angle = res.hidden ? '0 : angle_out(vy_z[N]);
    end

    // output register with skid
    logic arrive, take_out;

    assign arrive   = en && r_vld[L-1];
    assign take_out = !r_out_v || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take_out) begin
            r_out_v  <= r_skid_v || arrive;
            r_skid_v <= 1'b0;
        end else if (arrive) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_out) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (arrive) begin
            r_skid <= res;
        end
    end

    assign o_out.valid   = r_out_v;
    assign o_out.x_angle = r_out.x_angle;
    assign o_out.y_angle = r_out.y_angle;
    assign o_out.hidden  = r_out.hidden;
endmodule
